/* rtl/assert_macros.svh */
// Assertion macros used by multichannel_input_qualifier_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/miq_pkg.sv */
`default_nettype none

package miq_pkg;

  localparam int CHANNELS_DEF   = 7;
  localparam int LEVEL_BITS_DEF = 16;
  localparam int THR_W          = 16;
  localparam int CNT_W          = 16;
  localparam int TYPE_W         = 2;
  localparam int APB_ADDR_W     = 5;
  localparam int APB_DATA_W     = 32;

  typedef enum logic [TYPE_W-1:0] {
    TYPE_LOW_VOLT  = 2'd0,
    TYPE_HIGH_VOLT = 2'd1
  } in_type_t;

  typedef enum logic [2:0] {
    REG_INPUT_TYPE = 3'd0,
    REG_POLARITY   = 3'd1,
    REG_ON_LO      = 3'd2,
    REG_OFF_LO     = 3'd3,
    REG_ON_HI      = 3'd4,
    REG_OFF_HI     = 3'd5,
    REG_HOLD       = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [THR_W-1:0] on_lvl;
    logic signed [THR_W-1:0] off_lvl;
    logic [CNT_W-1:0]        hold_ticks;
  } thr_t;

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] data;
  } cnt_wr_t;

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] cnt;
    logic             bit_next;
  } qual_t;

endpackage

`default_nettype wire

/* rtl/multichannel_input_qualifier_core.sv */
// Channel  Direction  Handshake          Payload
// in       sink       in_valid/in_stall   in_channel, in_level
// out      source     out_valid/out_stall out_qualified_bits, out_channel_active
// cfg      APB slave  psel/penable/pready paddr, pwdata, prdata
//
// One beat is taken every cycle unless stalled; its result reaches the output register.
// The accept edge reads the counter RAM; the s1_adv edge writes it and loads the output.
// A write of the previous beat to the same channel is forwarded around the RAM.
// Reset is synchronous and clears all control state and the counter valid bits at once.
// in_stall rises only when the working stage is full and a held result is stalled.
`default_nettype none
`include "assert_macros.svh"

module multichannel_input_qualifier_core
  import miq_pkg::*;
#(
  parameter  int CHANNELS   = CHANNELS_DEF,
  parameter  int LEVEL_BITS = LEVEL_BITS_DEF,
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic        [CH_W-1:0]       in_channel,
  input  wire logic signed [LEVEL_BITS-1:0] in_level,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic             [CHANNELS-1:0]   out_qualified_bits,
  output logic                              out_channel_active,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic        [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic        [APB_DATA_W-1:0] cfg_pwdata,
  output logic             [APB_DATA_W-1:0] cfg_prdata,
  output logic                              cfg_pready
);

  logic                           s1_valid_r;
  logic                           s1_inr_r;
  logic [CH_W-1:0]                s1_chan_r;
  logic signed [LEVEL_BITS-1:0]   s1_level_r;
  logic [CHANNELS-1:0]            logic_bits_r;
  logic [CHANNELS-1:0]            logic_bits_nxt;
  logic                           out_valid_r;
  logic [CHANNELS-1:0]            out_qualified_bits_r;
  logic                           out_channel_active_r;
  logic                           out_free;
  logic                           s1_adv;
  logic                           accept;
  logic                           in_range;
  logic                           is_set;
  logic                           inverted;
  logic [CHANNELS-1:0]            polarity;
  logic [CNT_W-1:0]               cnt_rd;
  thr_t                           thr;
  qual_t                          upd;
  cnt_wr_t                        cnt_wr;

  miq_cfg_regs #(
    .CHANNELS(CHANNELS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .polarity(polarity),
    .thr     (thr)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(in_channel) < CHANNELS);

  miq_cnt_ram #(
    .CHANNELS(CHANNELS)
  ) u_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept && in_range),
    .rd_addr(in_channel),
    .wr     (cnt_wr),
    .wr_addr(s1_chan_r),
    .rd_data(cnt_rd)
  );

  assign is_set   = s1_inr_r && logic_bits_r[s1_chan_r];
  assign inverted = s1_inr_r && polarity[s1_chan_r];

  miq_qualify #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_qual (
    .level   (s1_level_r),
    .thr     (thr),
    .cnt     (cnt_rd),
    .is_set  (is_set),
    .inverted(inverted),
    .upd     (upd)
  );

  assign cnt_wr.we   = s1_adv && s1_inr_r && upd.we;
  assign cnt_wr.data = upd.cnt;

  always_comb begin
    logic_bits_nxt = logic_bits_r;
    if (s1_inr_r) begin
      logic_bits_nxt[s1_chan_r] = upd.bit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_chan_r  <= in_channel;
      s1_level_r <= in_level;
      s1_inr_r   <= in_range;
    end
    if (s1_adv) begin
      out_qualified_bits_r <= logic_bits_nxt;
      out_channel_active_r <= s1_inr_r && upd.bit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      logic_bits_r <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r  <= 1'b1;
        logic_bits_r <= logic_bits_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_qualified_bits = out_qualified_bits_r;
  assign out_channel_active = out_channel_active_r;

  `ASSERT_IMPLY(a_stall_when_full, clk, rst_n, s1_valid_r && out_valid_r && out_stall, in_stall)
  `ASSERT_IMPLY(a_active_bit_set, clk, rst_n, out_valid_r && out_channel_active_r, out_qualified_bits_r != '0)
  `ASSERT_NEXT(a_bits_hold, clk, rst_n, !s1_adv, $stable(logic_bits_r))
  `ASSERT_ALWAYS(a_write_on_advance, clk, rst_n, !cnt_wr.we || s1_adv)

endmodule

`default_nettype wire

/* rtl/miq_cfg_regs.sv */
`default_nettype none

module miq_cfg_regs
  import miq_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [CHANNELS-1:0]   polarity,
  output thr_t                       thr
);

  logic [TYPE_W-1:0]   type_r;
  logic [CHANNELS-1:0] polarity_r;
  logic [THR_W-1:0]    on_lo_r;
  logic [THR_W-1:0]    off_lo_r;
  logic [THR_W-1:0]    on_hi_r;
  logic [THR_W-1:0]    off_hi_r;
  logic [CNT_W-1:0]    hold_r;
  logic                wr_en;
  reg_idx_t            idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r     <= '0;
      polarity_r <= '0;
      on_lo_r    <= '0;
      off_lo_r   <= '0;
      on_hi_r    <= '0;
      off_hi_r   <= '0;
      hold_r     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_INPUT_TYPE: type_r     <= pwdata[TYPE_W-1:0];
        REG_POLARITY:   polarity_r <= pwdata[CHANNELS-1:0];
        REG_ON_LO:      on_lo_r    <= pwdata[THR_W-1:0];
        REG_OFF_LO:     off_lo_r   <= pwdata[THR_W-1:0];
        REG_ON_HI:      on_hi_r    <= pwdata[THR_W-1:0];
        REG_OFF_HI:     off_hi_r   <= pwdata[THR_W-1:0];
        REG_HOLD:       hold_r     <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INPUT_TYPE: prdata = APB_DATA_W'(type_r);
      REG_POLARITY:   prdata = APB_DATA_W'(polarity_r);
      REG_ON_LO:      prdata = APB_DATA_W'(on_lo_r);
      REG_OFF_LO:     prdata = APB_DATA_W'(off_lo_r);
      REG_ON_HI:      prdata = APB_DATA_W'(on_hi_r);
      REG_OFF_HI:     prdata = APB_DATA_W'(off_hi_r);
      REG_HOLD:       prdata = APB_DATA_W'(hold_r);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    thr.hold_ticks = hold_r;
    unique case (in_type_t'(type_r))
      TYPE_LOW_VOLT: begin
        thr.on_lvl  = on_lo_r;
        thr.off_lvl = off_lo_r;
      end
      TYPE_HIGH_VOLT: begin
        thr.on_lvl  = on_hi_r;
        thr.off_lvl = off_hi_r;
      end
      default: begin
        thr.on_lvl  = '0;
        thr.off_lvl = '0;
      end
    endcase
  end

  assign polarity = polarity_r;

endmodule

`default_nettype wire

/* rtl/miq_cnt_ram.sv */
`default_nettype none

module miq_cnt_ram
  import miq_pkg::*;
#(
  parameter  int CHANNELS = CHANNELS_DEF,
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_en,
  input  wire logic [CH_W-1:0] rd_addr,
  input  wire cnt_wr_t         wr,
  input  wire logic [CH_W-1:0] wr_addr,
  output logic     [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0]    mem [CHANNELS];
  logic [CNT_W-1:0]    mem_q_r;
  logic [CNT_W-1:0]    fwd_data_r;
  logic [CHANNELS-1:0] vld_r;
  logic                hit_r;
  logic                fwd_r;
  logic                same;

  assign same = wr.we && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr_addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      fwd_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      if (wr.we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= vld_r[rd_addr];
        fwd_r <= same;
      end
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : (hit_r ? mem_q_r : '0);

endmodule

`default_nettype wire

/* rtl/miq_qualify.sv */
`default_nettype none

module miq_qualify
  import miq_pkg::*;
#(
  parameter  int LEVEL_BITS = LEVEL_BITS_DEF,
  localparam int CMP_W      = (LEVEL_BITS > THR_W) ? LEVEL_BITS : THR_W
) (
  input  wire logic signed [LEVEL_BITS-1:0] level,
  input  wire thr_t                         thr,
  input  wire logic        [CNT_W-1:0]      cnt,
  input  wire logic                         is_set,
  input  wire logic                         inverted,
  output qual_t                             upd
);

  logic signed [THR_W-1:0] on_s;
  logic signed [THR_W-1:0] off_s;
  logic signed [CMP_W-1:0] lvl_x;
  logic signed [CMP_W-1:0] on_x;
  logic signed [CMP_W-1:0] off_x;
  logic                    fire;
  logic [CNT_W-1:0]        cnt_adv;

  assign on_s    = thr.on_lvl;
  assign off_s   = thr.off_lvl;
  assign lvl_x   = CMP_W'(level);
  assign on_x    = CMP_W'(on_s);
  assign off_x   = CMP_W'(off_s);
  assign fire    = (cnt >= thr.hold_ticks);
  assign cnt_adv = fire ? '0 : cnt + CNT_W'(1);

  always_comb begin
    upd.we       = 1'b0;
    upd.cnt      = cnt_adv;
    upd.bit_next = is_set;
    if (!inverted) begin
      if (is_set) begin
        if (lvl_x <= off_x) begin
          upd.bit_next = 1'b0;
        end
      end else if (lvl_x >= on_x) begin
        upd.we = 1'b1;
        if (fire) begin
          upd.bit_next = 1'b1;
        end
      end else begin
        upd.we  = 1'b1;
        upd.cnt = '0;
      end
    end else begin
      if (is_set) begin
        upd.we = 1'b1;
        if (lvl_x < off_x) begin
          if (fire) begin
            upd.bit_next = 1'b0;
          end
        end else begin
          upd.cnt = '0;
        end
      end else if (lvl_x > on_x) begin
        upd.bit_next = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/tb_multichannel_input_qualifier_core.sv */
`timescale 1ns / 1ps

module tb_multichannel_input_qualifier_core;
  import miq_pkg::*;

  localparam int NUM_CH         = CHANNELS_DEF;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLDOFF_CYCLES = 160;
  localparam int PHASE_SAMPLES  = 153;

  localparam logic [TYPE_W-1:0] TYPE_ZERO_THR = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_ZERO_ALT = 2'd3;

  typedef struct packed {
    logic [2:0]         ch;
    logic signed [15:0] lvl;
  } sample_t;

  typedef struct packed {
    logic [NUM_CH-1:0] bits;
    logic              active;
  } qual_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pattern_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               in_channel = '0;
  logic signed [15:0]       in_level = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [NUM_CH-1:0]        out_qualified_bits;
  logic                     out_channel_active;
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]    cfg_paddr = '0;
  logic [APB_DATA_W-1:0]    cfg_pwdata = '0;
  logic [APB_DATA_W-1:0]    cfg_prdata;
  logic                     cfg_pready;

  logic [1:0]               cfg_type = '0;
  logic [NUM_CH-1:0]        cfg_polarity = '0;
  logic signed [15:0]       cfg_on_lo = '0;
  logic signed [15:0]       cfg_off_lo = '0;
  logic signed [15:0]       cfg_on_hi = '0;
  logic signed [15:0]       cfg_off_hi = '0;
  logic [15:0]              cfg_hold = '0;
  logic [15:0]              hold_cnt [NUM_CH];
  logic [NUM_CH-1:0]        qual_bits = '0;

  sample_t                  pending_samples [$];
  qual_result_t             expected_results [$];

  logic                     sample_taken = 1'b0;
  int                       send_burst = 1;
  int                       send_gap = 0;
  stall_pattern_t           stall_mode = STALL_NONE;
  int                       stall_mode_left = 0;
  int                       holdoff_left = 0;
  int                       next_holdoff_at = 200;
  int                       holdoffs_done = 0;
  int                       samples_accepted = 0;
  int                       results_checked = 0;
  int                       input_stall_cycles = 0;
  int                       settings_applied = 0;
  int                       error_count = 0;
  int                       cycle_count = 0;

  multichannel_input_qualifier_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_channel         (in_channel),
    .in_level           (in_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_qualified_bits (out_qualified_bits),
    .out_channel_active (out_channel_active),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always #2 clk = ~clk;

  function automatic void report_error(input string msg);
    if (error_count < 10) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endfunction

  function automatic logic advance_hold(input int c);
    if (hold_cnt[c] >= cfg_hold) begin
      hold_cnt[c] = '0;
      return 1'b1;
    end
    hold_cnt[c] = hold_cnt[c] + 16'd1;
    return 1'b0;
  endfunction

  function automatic void qualify_sample(input logic [2:0] ch, input logic signed [15:0] lvl);
    logic signed [15:0] on_thr;
    logic signed [15:0] off_thr;
    qual_result_t       r;
    on_thr = '0;
    off_thr = '0;
    r.active = 1'b0;
    if (cfg_type == TYPE_LOW_VOLT) begin
      on_thr = cfg_on_lo;
      off_thr = cfg_off_lo;
    end else if (cfg_type == TYPE_HIGH_VOLT) begin
      on_thr = cfg_on_hi;
      off_thr = cfg_off_hi;
    end
    if (ch < NUM_CH) begin
      if (!cfg_polarity[ch]) begin
        if (qual_bits[ch]) begin
          if (lvl <= off_thr) qual_bits[ch] = 1'b0;
        end else if (lvl >= on_thr) begin
          if (advance_hold(ch)) qual_bits[ch] = 1'b1;
        end else begin
          hold_cnt[ch] = '0;
        end
      end else begin
        if (qual_bits[ch]) begin
          if (lvl < off_thr) begin
            if (advance_hold(ch)) qual_bits[ch] = 1'b0;
          end else begin
            hold_cnt[ch] = '0;
          end
        end else if (lvl > on_thr) begin
          qual_bits[ch] = 1'b1;
        end
      end
      r.active = qual_bits[ch];
    end
    r.bits = qual_bits;
    expected_results.push_back(r);
  endfunction

  function automatic logic signed [15:0] level_between(input int lo, input int hi);
    return 16'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task automatic queue_sample(input logic [2:0] ch, input int lvl);
    sample_t s;
    s.ch = ch;
    s.lvl = 16'(lvl);
    pending_samples.push_back(s);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] data);
    logic [31:0] mask;
    logic [31:0] readback;
    case (idx)
      REG_INPUT_TYPE: mask = 32'h3;
      REG_POLARITY:   mask = 32'h7F;
      default:        mask = 32'hFFFF;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if ((readback & mask) !== (data & mask)) begin
      report_error($sformatf("register %s read back %h, expected %h",
                             idx.name(), readback & mask, data & mask));
    end
    case (idx)
      REG_INPUT_TYPE: cfg_type = data[1:0];
      REG_POLARITY:   cfg_polarity = data[NUM_CH-1:0];
      REG_ON_LO:      cfg_on_lo = data[15:0];
      REG_OFF_LO:     cfg_off_lo = data[15:0];
      REG_ON_HI:      cfg_on_hi = data[15:0];
      REG_OFF_HI:     cfg_off_hi = data[15:0];
      default:        cfg_hold = data[15:0];
    endcase
  endtask

  task automatic apply_settings(input logic [1:0] kind, input logic [6:0] pol,
                                input int on_lo, input int off_lo,
                                input int on_hi, input int off_hi, input int hold);
    cfg_write(REG_INPUT_TYPE, 32'(kind));
    cfg_write(REG_POLARITY, 32'(pol));
    cfg_write(REG_ON_LO, 32'(on_lo));
    cfg_write(REG_OFF_LO, 32'(off_lo));
    cfg_write(REG_ON_HI, 32'(on_hi));
    cfg_write(REG_OFF_HI, 32'(off_hi));
    cfg_write(REG_HOLD, 32'(hold));
    settings_applied++;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Runs of samples on one channel on the same side of a threshold, so that
  // debounce counts complete, mixed with full-range noise and bad channels.
  task automatic queue_random_samples(input int count);
    int                 on_i;
    int                 off_i;
    int                 run_len;
    int                 side;
    int                 pick;
    logic [2:0]         ch;
    logic signed [15:0] lvl;
    on_i = 0;
    off_i = 0;
    if (cfg_type == TYPE_LOW_VOLT) begin
      on_i = cfg_on_lo;
      off_i = cfg_off_lo;
    end else if (cfg_type == TYPE_HIGH_VOLT) begin
      on_i = cfg_on_hi;
      off_i = cfg_off_hi;
    end
    while (count > 0) begin
      ch = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, NUM_CH - 1));
      side = $urandom_range(0, 9);
      run_len = $urandom_range(1, (cfg_hold > 6) ? 10 : int'(cfg_hold) + 3);
      repeat (run_len) begin
        if (count > 0) begin
          pick = $urandom_range(0, 3);
          if (side < 4) begin
            if (pick == 0) lvl = 16'(on_i);
            else if (pick == 1) lvl = level_between(on_i, (on_i > 32765) ? 32767 : on_i + 2);
            else lvl = level_between(on_i, 32767);
          end else if (side < 8) begin
            if (pick == 0) lvl = 16'(off_i);
            else if (pick == 1) lvl = level_between((off_i < -32766) ? -32768 : off_i - 2,
                                                    off_i);
            else lvl = level_between(-32768, off_i);
          end else begin
            lvl = 16'($urandom);
          end
          queue_sample(ch, lvl);
          count--;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    qual_result_t want;
    sample_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result bits=%b active=%b",
                                 out_qualified_bits, out_channel_active));
        end else begin
          want = expected_results.pop_front();
          if (out_qualified_bits !== want.bits) begin
            report_error($sformatf("qualified_bits %b, expected %b",
                                   out_qualified_bits, want.bits));
          end
          if (out_channel_active !== want.active) begin
            report_error($sformatf("channel_active %b, expected %b",
                                   out_channel_active, want.active));
          end
        end
      end
      if (in_valid && in_stall) input_stall_cycles++;
      if (in_valid && !in_stall) begin
        qualify_sample(in_channel, in_level);
        samples_accepted++;
      end
    end
  end

  always @(negedge clk) begin
    sample_t s;
    if (!in_valid || sample_taken) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_samples.size() != 0) begin
        s = pending_samples.pop_front();
        in_valid <= 1'b1;
        in_channel <= s.ch;
        in_level <= s.lvl;
        if (send_burst > 1) begin
          send_burst <= send_burst - 1;
        end else begin
          send_burst <= $urandom_range(1, 24);
          send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The long hold-off lets the sender run into a full pipeline.
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode <= stall_pattern_t'($urandom_range(0, 3));
      stall_mode_left <= $urandom_range(20, 120);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    if (holdoff_left != 0) begin
      out_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (samples_accepted >= next_holdoff_at) begin
      out_stall <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES;
      next_holdoff_at <= next_holdoff_at + 500;
      holdoffs_done <= holdoffs_done + 1;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= cycle_count[2];
      endcase
    end
  end

  initial begin
    foreach (hold_cnt[c]) hold_cnt[c] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Normal mode on channel 0, inverted mode on channel 6, hold of three samples.
    apply_settings(TYPE_LOW_VOLT, 7'h40, 100, -100, 32767, -32768, 2);
    queue_sample(3'd0, 100);
    queue_sample(3'd0, 100);
    queue_sample(3'd0, 99);
    queue_sample(3'd0, 100);
    queue_sample(3'd0, 100);
    queue_sample(3'd0, 100);
    queue_sample(3'd0, -99);
    queue_sample(3'd0, -100);
    queue_sample(3'd6, 100);
    queue_sample(3'd6, 101);
    queue_sample(3'd6, -101);
    queue_sample(3'd6, -101);
    queue_sample(3'd6, -100);
    queue_sample(3'd6, -101);
    queue_sample(3'd6, -101);
    queue_sample(3'd6, -101);
    queue_sample(3'd7, 32767);
    queue_sample(3'd7, -32768);
    queue_sample(3'd5, 32767);
    queue_sample(3'd3, -32768);
    wait_idle();

    // A counter left above a lowered hold length fires on the next qualifying sample.
    cfg_write(REG_HOLD, 32'd5);
    repeat (4) queue_sample(3'd2, 200);
    wait_idle();
    cfg_write(REG_HOLD, 32'd1);
    queue_sample(3'd2, 200);
    wait_idle();

    apply_settings(TYPE_LOW_VOLT, 7'h00, 1000, -1000, 20000, 5000, 2);
    queue_random_samples(PHASE_SAMPLES);
    wait_idle();
    apply_settings(TYPE_HIGH_VOLT, 7'h7F, $urandom, $urandom, 500, 400, 0);
    queue_random_samples(PHASE_SAMPLES);
    wait_idle();
    apply_settings(TYPE_ZERO_THR, 7'($urandom), $urandom, $urandom, $urandom, $urandom, 1);
    queue_random_samples(PHASE_SAMPLES);
    wait_idle();
    apply_settings(TYPE_ZERO_ALT, 7'($urandom), $urandom, $urandom, $urandom, $urandom, 3);
    queue_random_samples(PHASE_SAMPLES);
    wait_idle();
    apply_settings(TYPE_LOW_VOLT, 7'h55, 32767, -32768, -32768, 32767, 0);
    queue_random_samples(PHASE_SAMPLES);
    wait_idle();
    apply_settings(TYPE_HIGH_VOLT, 7'h2A, 32767, -32768, -32768, 32767, 4);
    queue_random_samples(PHASE_SAMPLES);
    wait_idle();
    apply_settings(TYPE_LOW_VOLT, 7'($urandom), $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, 5));
    queue_random_samples(PHASE_SAMPLES);
    wait_idle();
    apply_settings(TYPE_HIGH_VOLT, 7'($urandom), $urandom, $urandom, $urandom_range(0, 3000),
                   -$urandom_range(0, 3000), 65535);
    queue_random_samples(PHASE_SAMPLES);
    wait_idle();
    apply_settings(TYPE_LOW_VOLT, 7'h7F, 0, 0, $urandom, $urandom, 65534);
    queue_random_samples(PHASE_SAMPLES);
    wait_idle();
    apply_settings(TYPE_HIGH_VOLT, 7'($urandom), $urandom, $urandom, $urandom, $urandom, 1);
    queue_random_samples(PHASE_SAMPLES);
    wait_idle();

    repeat (20) @(posedge clk);
    $display("Checked %0d results from %0d samples under %0d threshold settings.",
             results_checked, samples_accepted, settings_applied);
    $display("Receiver held off %0d times; input stalled for %0d cycles.",
             holdoffs_done, input_stall_cycles);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total.", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/miq_pkg.sv
rtl/miq_cfg_regs.sv
rtl/miq_cnt_ram.sv
rtl/miq_qualify.sv
rtl/multichannel_input_qualifier_core.sv
tb/tb_multichannel_input_qualifier_core.sv
